>>> rtl/frx_pkg.sv
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types, constants and the Fletcher fold for the framed packet receiver
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hAA;
  localparam logic [7:0] SYNC_SECOND  = 8'h55;
  localparam logic [8:0] FLETCHER_MOD = 9'd255;

  // number of data bytes after the sync pair (x, y, z, yaw, waypoint state)
  localparam int unsigned FIELD_COUNT = 17;

  localparam logic [4:0] POS_FIRST_FIELD = 5'd2;
  localparam logic [4:0] POS_CHECK_LOW   = 5'd19;
  localparam logic [4:0] POS_CHECK_HIGH  = 5'd20;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2,
    PH_SPARE   = 2'd3
  } frx_phase_t;

  // control from the sequencer to the byte chain and output stage
  typedef struct packed {
    logic shift_en;       // accepted data byte enters the chain
    logic final_pending;  // next byte is the checksum high byte
    logic emit;           // accepted final byte and checksum matched
  } frx_ctl_t;

  // one modulo-255 accumulate step, acc in 0..254 and b in 0..255, result in 0..254
  function automatic logic [7:0] fold(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, acc} + {1'b0, b};
    if (t >= FLETCHER_MOD) begin
      t = t - FLETCHER_MOD;
    end
    return t[7:0];
  endfunction

endpackage

>>> rtl/frx_cell.sv
// ----------------------------------------------------------------------------
// frx_cell
// One byte stage of the packet shift chain
// ----------------------------------------------------------------------------
module frx_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  assign data_nxt = shift_en ? byte_in : data_r;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign byte_out = data_r;

endmodule

>>> rtl/frx_ctrl.sv
// ----------------------------------------------------------------------------
// frx_ctrl
// Sync hunt sequencer with running Fletcher-16 sums and checksum compare
// ----------------------------------------------------------------------------
module frx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_acc,
  input  logic [7:0]       rx_byte,
  output frx_pkg::frx_ctl_t ctl
);

  frx_pkg::frx_phase_t phase_r, phase_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [7:0] sum_low_r, sum_low_nxt;
  logic [7:0] sum_high_r, sum_high_nxt;
  logic [7:0] chk_low_r, chk_low_nxt;
  logic [7:0] low_f, high_f;

  assign low_f  = frx_pkg::fold(sum_low_r, rx_byte);
  assign high_f = frx_pkg::fold(sum_high_r, low_f);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= frx_pkg::PH_HUNT;
      pos_r      <= '0;
      sum_low_r  <= '0;
      sum_high_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      sum_low_r  <= sum_low_nxt;
      sum_high_r <= sum_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_low_r <= chk_low_nxt;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    sum_low_nxt   = sum_low_r;
    sum_high_nxt  = sum_high_r;
    chk_low_nxt   = chk_low_r;
    ctl           = '0;
    ctl.final_pending = (phase_r == frx_pkg::PH_COLLECT) &&
                        (pos_r == frx_pkg::POS_CHECK_HIGH);
    if (byte_acc) begin
      unique case (phase_r)
        frx_pkg::PH_SECOND: begin
          if (rx_byte == frx_pkg::SYNC_SECOND) begin
            sum_low_nxt  = low_f;
            sum_high_nxt = high_f;
            phase_nxt    = frx_pkg::PH_COLLECT;
            pos_nxt      = frx_pkg::POS_FIRST_FIELD;
          end else begin
            phase_nxt = frx_pkg::PH_HUNT;
            pos_nxt   = '0;
          end
        end
        frx_pkg::PH_COLLECT: begin
          priority if (pos_r < frx_pkg::POS_CHECK_LOW) begin
            ctl.shift_en = 1'b1;
            sum_low_nxt  = low_f;
            sum_high_nxt = high_f;
            pos_nxt      = pos_r + 5'd1;
          end else if (pos_r == frx_pkg::POS_CHECK_LOW) begin
            chk_low_nxt = rx_byte;
            pos_nxt     = pos_r + 5'd1;
          end else begin
            phase_nxt = frx_pkg::PH_HUNT;
            pos_nxt   = '0;
            ctl.emit  = (chk_low_r == sum_low_r) && (rx_byte == sum_high_r);
          end
        end
        default: begin
          // hunting, the spare code behaves the same
          phase_nxt = frx_pkg::PH_HUNT;
          pos_nxt   = '0;
          if (rx_byte == frx_pkg::SYNC_FIRST) begin
            sum_low_nxt  = frx_pkg::fold(8'd0, rx_byte);
            sum_high_nxt = frx_pkg::fold(8'd0, frx_pkg::fold(8'd0, rx_byte));
            phase_nxt    = frx_pkg::PH_SECOND;
            pos_nxt      = 5'd1;
          end
        end
      endcase
    end
  end

  // position tracks the phase
  a_pos_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frx_pkg::PH_COLLECT) |->
      (pos_r >= frx_pkg::POS_FIRST_FIELD && pos_r <= frx_pkg::POS_CHECK_HIGH))
    else $error("collect position out of range");

  a_pos_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frx_pkg::PH_HUNT) |-> (pos_r == 5'd0))
    else $error("hunt phase with nonzero position");

  // sums stay below the modulus
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_low_r != 8'hFF) && (sum_high_r != 8'hFF))
    else $error("fletcher sum reached 255");

endmodule

>>> rtl/sync_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver
// Sync-framed 21-byte packet receiver with Fletcher-16 check
// ----------------------------------------------------------------------------
// Takes one serial byte per request and hunts for the sync pair 0xAA 0x55,
// then collects 17 data bytes (x, y, z, yaw as little-endian 32-bit words,
// then the waypoint state byte) and the two checksum bytes, low first. The
// Fletcher-16 sums (modulo 255) run over the first 19 bytes, sync included,
// and are updated as each byte arrives. Data bytes move through a chain of
// 17 byte cells, so no addressed storage is involved. A good packet gives one
// result request the cycle after its last byte is taken; a bad one is dropped
// silently. Input takes one byte every cycle; the only stall comes when the
// final checksum byte arrives while the previous result is still held by a
// stalled output, in which case in_stall is high until that result leaves.
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pos_x_bits,
  output logic [31:0] out_pos_y_bits,
  output logic [31:0] out_pos_z_bits,
  output logic [31:0] out_yaw_bits,
  output logic [7:0]  out_wp_status
);

  frx_pkg::frx_ctl_t ctl;
  logic              in_acc;
  logic              out_acc;

  // byte chain taps: tap 0 is packet byte 2 once a packet is complete
  logic [7:0] tap [frx_pkg::FIELD_COUNT];

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] pos_x_r, pos_y_r, pos_z_r, yaw_r;
  logic [7:0]  wp_state_r;

  // hold input only when a result must be written into a full, stalled output
  assign in_stall = ctl.final_pending && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  frx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (in_acc),
    .rx_byte  (in_rx_byte),
    .ctl      (ctl)
  );

  // shift chain: newest byte enters at the top cell and moves down
  for (genvar i = 0; i < frx_pkg::FIELD_COUNT; i++) begin : g_cell
    if (i == frx_pkg::FIELD_COUNT - 1) begin : g_top
      frx_cell u_cell (
        .clk      (clk),
        .shift_en (ctl.shift_en),
        .byte_in  (in_rx_byte),
        .byte_out (tap[i])
      );
    end else begin : g_mid
      frx_cell u_cell (
        .clk      (clk),
        .shift_en (ctl.shift_en),
        .byte_in  (tap[i+1]),
        .byte_out (tap[i])
      );
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload capture, little-endian assembly of the four words
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pos_x_r    <= {tap[3],  tap[2],  tap[1],  tap[0]};
      pos_y_r    <= {tap[7],  tap[6],  tap[5],  tap[4]};
      pos_z_r    <= {tap[11], tap[10], tap[9],  tap[8]};
      yaw_r      <= {tap[15], tap[14], tap[13], tap[12]};
      wp_state_r <= tap[16];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x_bits = pos_x_r;
  assign out_pos_y_bits = pos_y_r;
  assign out_pos_z_bits = pos_z_r;
  assign out_yaw_bits   = yaw_r;
  assign out_wp_status  = wp_state_r;

  // a result only ever comes from an accepted final byte
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (in_acc && ctl.final_pending))
    else $error("result without accepted checksum byte");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // new result is presented the cycle after the emitting byte
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

>>> verif/frx_packet_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frx_packet_checker
// Watches both channels of the framed packet receiver and checks its results
// ----------------------------------------------------------------------------
// Tracks the sync hunt, the running Fletcher-16 sums and the packet body on
// every accepted byte, queues the packet each good checksum should produce,
// and compares every accepted result field by field against the oldest one.
// ----------------------------------------------------------------------------
module frx_packet_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_pos_x_bits,
  input  logic [31:0] out_pos_y_bits,
  input  logic [31:0] out_pos_z_bits,
  input  logic [31:0] out_yaw_bits,
  input  logic [7:0]  out_wp_status,
  output int          mismatch_count,
  output int          packets_owed
);

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] yaw;
    logic [7:0]  waypoint;
  } nav_packet_t;

  frx_pkg::frx_phase_t scan_phase;
  logic [4:0]  next_pos;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  body [frx_pkg::FIELD_COUNT];
  logic [7:0]  check_lo;
  nav_packet_t expected_packets [$];

  // modulo-255 running sum step
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    int s;
    s = (int'(a) + int'(b)) % 255;
    return s[7:0];
  endfunction

  task automatic fold_in(input logic [7:0] b);
    sum_a = add_mod255(sum_a, b);
    sum_b = add_mod255(sum_b, sum_a);
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    nav_packet_t pkt;
    case (scan_phase)
      frx_pkg::PH_SECOND: begin
        // a wrong second sync byte is dropped, not retried as a first one
        if (b == frx_pkg::SYNC_SECOND) begin
          fold_in(b);
          scan_phase = frx_pkg::PH_COLLECT;
          next_pos = frx_pkg::POS_FIRST_FIELD;
        end else begin
          scan_phase = frx_pkg::PH_HUNT;
          next_pos = '0;
        end
      end
      frx_pkg::PH_COLLECT: begin
        if (next_pos >= frx_pkg::POS_FIRST_FIELD && next_pos < frx_pkg::POS_CHECK_LOW) begin
          body[next_pos - frx_pkg::POS_FIRST_FIELD] = b;
          fold_in(b);
          next_pos = next_pos + 5'd1;
        end else if (next_pos == frx_pkg::POS_CHECK_LOW) begin
          check_lo = b;
          next_pos = next_pos + 5'd1;
        end else begin
          scan_phase = frx_pkg::PH_HUNT;
          next_pos = '0;
          if (check_lo == sum_a && b == sum_b) begin
            pkt.pos_x    = {body[3], body[2], body[1], body[0]};
            pkt.pos_y    = {body[7], body[6], body[5], body[4]};
            pkt.pos_z    = {body[11], body[10], body[9], body[8]};
            pkt.yaw      = {body[15], body[14], body[13], body[12]};
            pkt.waypoint = body[16];
            expected_packets.push_back(pkt);
          end
        end
      end
      default: begin
        scan_phase = frx_pkg::PH_HUNT;
        next_pos = '0;
        if (b == frx_pkg::SYNC_FIRST) begin
          sum_a = '0;
          sum_b = '0;
          fold_in(b);
          scan_phase = frx_pkg::PH_SECOND;
          next_pos = 5'd1;
        end
      end
    endcase
  endtask

  task automatic compare_packet();
    nav_packet_t want;
    if (expected_packets.size() == 0) begin
      $error("result with none expected: x=%h y=%h z=%h yaw=%h wp=%h",
             out_pos_x_bits, out_pos_y_bits, out_pos_z_bits, out_yaw_bits,
             out_wp_status);
      mismatch_count++;
      return;
    end
    want = expected_packets.pop_front();
    if (out_pos_x_bits !== want.pos_x) begin
      $error("pos_x_bits: expected %h, actual %h", want.pos_x, out_pos_x_bits);
      mismatch_count++;
    end
    if (out_pos_y_bits !== want.pos_y) begin
      $error("pos_y_bits: expected %h, actual %h", want.pos_y, out_pos_y_bits);
      mismatch_count++;
    end
    if (out_pos_z_bits !== want.pos_z) begin
      $error("pos_z_bits: expected %h, actual %h", want.pos_z, out_pos_z_bits);
      mismatch_count++;
    end
    if (out_yaw_bits !== want.yaw) begin
      $error("yaw_bits: expected %h, actual %h", want.yaw, out_yaw_bits);
      mismatch_count++;
    end
    if (out_wp_status !== want.waypoint) begin
      $error("wp_status: expected %h, actual %h", want.waypoint, out_wp_status);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_phase = frx_pkg::PH_HUNT;
      next_pos = '0;
      sum_a = '0;
      sum_b = '0;
      check_lo = '0;
      expected_packets.delete();
    end else begin
      if (in_valid && !in_stall) begin
        absorb_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        compare_packet();
      end
    end
    packets_owed = expected_packets.size();
  end

endmodule

>>> verif/tb_sync_framed_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_framed_packet_receiver
// Byte-stream stimulus and verdict for the framed packet receiver
// ----------------------------------------------------------------------------
// Feeds a byte stream made mostly of well-formed 21-byte packets with random
// bodies, mixed with bad checksums, 0xFF checksum bytes, broken sync pairs
// and loose noise. The sender runs in bursts, the receiver stalls on its own
// pattern with one long hold-off, and a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_sync_framed_packet_receiver;

  localparam int RANDOM_BYTES = 1400;
  localparam int IDLE_LIMIT   = 3000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 8;     // result shows the cycle after the last byte

  typedef enum int {
    FR_GOOD,
    FR_BAD_LOW,
    FR_BAD_HIGH,
    FR_CHECK_FF,
    FR_BROKEN_SYNC,
    FR_NOISE
  } frame_kind_t;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] out_pos_x_bits;
  logic [31:0] out_pos_y_bits;
  logic [31:0] out_pos_z_bits;
  logic [31:0] out_yaw_bits;
  logic [7:0]  out_wp_status;

  int mismatch_count;
  int packets_owed;
  int burst_left  = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit start_hold  = 1'b0;

  sync_framed_packet_receiver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x_bits (out_pos_x_bits),
    .out_pos_y_bits (out_pos_y_bits),
    .out_pos_z_bits (out_pos_z_bits),
    .out_yaw_bits   (out_yaw_bits),
    .out_wp_status  (out_wp_status)
  );

  frx_packet_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x_bits (out_pos_x_bits),
    .out_pos_y_bits (out_pos_y_bits),
    .out_pos_z_bits (out_pos_z_bits),
    .out_yaw_bits   (out_yaw_bits),
    .out_wp_status  (out_wp_status),
    .mismatch_count (mismatch_count),
    .packets_owed   (packets_owed)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // modulo-255 step, only used to build valid checksums for the stream
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    int s;
    s = (int'(a) + int'(b)) % 255;
    return s[7:0];
  endfunction

  // one byte request; called at a falling edge and returns at a falling edge.
  // a fresh burst may open with an idle gap, but in_valid is only lowered
  // when the gap is real so it never gets two updates in one step
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // taken at the first rising edge with stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  // full 21-byte frame: sync, 17 body bytes, checksum low then high.
  // the checksum is damaged on purpose for the bad-frame kinds
  task automatic send_frame(input frame_kind_t kind, input fill_t fill);
    logic [7:0] body [frx_pkg::FIELD_COUNT];
    logic [7:0] s_lo;
    logic [7:0] s_hi;
    int i;
    case (fill)
      FILL_ZERO:   foreach (body[k]) body[k] = 8'h00;
      FILL_ONES:   foreach (body[k]) body[k] = 8'hFF;
      default:     foreach (body[k]) body[k] = 8'($urandom_range(0, 255));
    endcase
    s_lo = add_mod255(8'h00, frx_pkg::SYNC_FIRST);
    s_hi = s_lo;
    s_lo = add_mod255(s_lo, frx_pkg::SYNC_SECOND);
    s_hi = add_mod255(s_hi, s_lo);
    for (i = 0; i < frx_pkg::FIELD_COUNT; i++) begin
      s_lo = add_mod255(s_lo, body[i]);
      s_hi = add_mod255(s_hi, s_lo);
    end
    case (kind)
      FR_BAD_LOW:  s_lo = s_lo ^ 8'($urandom_range(1, 255));
      FR_BAD_HIGH: s_hi = s_hi ^ 8'($urandom_range(1, 255));
      // sums never reach 0xFF, so this byte can never match
      FR_CHECK_FF: begin
        if ($urandom_range(0, 1) == 0) begin
          s_lo = 8'hFF;
        end else begin
          s_hi = 8'hFF;
        end
      end
      default: ;
    endcase
    send_byte(frx_pkg::SYNC_FIRST);
    send_byte(frx_pkg::SYNC_SECOND);
    for (i = 0; i < frx_pkg::FIELD_COUNT; i++) begin
      send_byte(body[i]);
    end
    send_byte(s_lo);
    send_byte(s_hi);
  endtask

  // hold requests back until every expected result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (packets_owed != 0);
  endtask

  // receiver stall pattern: segments of varying stall density, plus one
  // long hold-off so the block backs up and stalls its input
  initial begin : receiver_pattern
    int  seg_left;
    int  stall_pct;
    bit  held;
    seg_left  = 0;
    stall_pct = 0;
    held      = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held && start_hold) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;     // no stalls at all
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      @(negedge clk);
    end
  end

  // watchdog: any cycle where a request moves on either side resets it
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int          pick;
    int          frames;
    int          n;
    logic [7:0]  junk;
    frame_kind_t kind;
    fill_t       fill;
    frames = 0;

    // synchronous reset
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: wrong second sync byte, then a doubled first sync byte
    // (the second 0xAA must not restart the hunt, so the 0x55 is ignored),
    // then a good frame with every body byte at its maximum
    send_byte(frx_pkg::SYNC_FIRST);
    send_byte(8'h00);
    send_byte(frx_pkg::SYNC_FIRST);
    send_byte(frx_pkg::SYNC_FIRST);
    send_byte(frx_pkg::SYNC_SECOND);
    send_frame(FR_GOOD, FILL_ONES);

    // random part: mostly well-formed frames with random bodies
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        kind = FR_GOOD;
      end else if (pick < 70) begin
        kind = FR_BAD_LOW;
      end else if (pick < 76) begin
        kind = FR_BAD_HIGH;
      end else if (pick < 82) begin
        kind = FR_CHECK_FF;
      end else if (pick < 90) begin
        kind = FR_BROKEN_SYNC;
      end else begin
        kind = FR_NOISE;
      end

      case (kind)
        FR_BROKEN_SYNC: begin
          do junk = 8'($urandom_range(0, 255)); while (junk == frx_pkg::SYNC_SECOND);
          send_byte(frx_pkg::SYNC_FIRST);
          send_byte(junk);
        end
        FR_NOISE: begin
          // loose bytes also knock later frames out of alignment
          n = $urandom_range(1, 5);
          repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          pick = $urandom_range(0, 9);
          fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
          send_frame(kind, fill);
        end
      endcase
      frames++;

      // long receiver hold-off while the stream keeps coming
      if (frames == 20) begin
        start_hold = 1'b1;
      end
      // sender pauses until the output side has caught up
      if (frames % 30 == 10) begin
        drain_results();
      end
    end

    // wind down: wait for outstanding results, then a short tail
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sync_framed_packet_receiver.f
rtl/frx_pkg.sv
rtl/frx_cell.sv
rtl/frx_ctrl.sv
rtl/sync_framed_packet_receiver.sv
verif/frx_packet_checker.sv
verif/tb_sync_framed_packet_receiver.sv
